// ----- sv/sdik_pkg.sv -----
package sdik_pkg;

  localparam int NumModules   = 4;
  localparam int CordicStages = 16;
  localparam int Deg360       = 23040;
  localparam int Deg180       = 11520;
  localparam int Deg90        = 5760;
  localparam int GainQ16      = 39797;
  localparam int Z180         = 2949120;

  localparam logic [1:0] RegRadius   = 2'd0;
  localparam logic [1:0] RegGain     = 2'd1;
  localparam logic [1:0] RegDeadband = 2'd2;

  typedef logic signed [47:0] wide_t;
  typedef logic signed [31:0] ang_t;

  function automatic ang_t atan_entry(input logic [4:0] i);
    case (i)
      5'd0: return 32'sd737280;
      5'd1: return 32'sd435242;
      5'd2: return 32'sd229970;
      5'd3: return 32'sd116736;
      5'd4: return 32'sd58595;
      5'd5: return 32'sd29326;
      5'd6: return 32'sd14667;
      5'd7: return 32'sd7334;
      5'd8: return 32'sd3667;
      5'd9: return 32'sd1833;
      5'd10: return 32'sd917;
      5'd11: return 32'sd458;
      5'd12: return 32'sd229;
      5'd13: return 32'sd115;
      5'd14: return 32'sd57;
      5'd15: return 32'sd29;
      5'd16: return 32'sd14;
      5'd17: return 32'sd7;
      5'd18: return 32'sd4;
      5'd19: return 32'sd2;
      5'd20: return 32'sd1;
      default: return 32'sd0;
    endcase
  endfunction

  typedef struct packed {
    logic              valid;
    logic [1:0]        idx;
    logic              last;
    logic signed [24:0] a;
    logic signed [16:0] w;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic              neg;
    wide_t             x;
    wide_t             y;
    ang_t              z;
  } tok_t;

endpackage

// ----- sv/swerve_drive_inverse_kinematics_top.sv -----
// Four-module swerve inverse kinematics. Each accepted item yields four results,
// module 0 first, one per cycle while the output side takes them; a new item is
// accepted no earlier than the issue of the last module of the previous item.
// Each result passes through one issue stage, a 16-cell rotate chain, two wheel
// vector stages, a 16-cell vector chain and three output stages. When mode_switch
// is 0 or 3 the item is taken and gives no result. The whole chain stalls together
// when the output register is full and not taken.
module swerve_drive_inverse_kinematics_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] vel_x,
  input  logic signed [15:0] vel_y,
  input  logic signed [15:0] yaw_rate,
  input  logic signed [23:0] heading,
  input  logic signed [23:0] heading_origin,
  input  logic [1:0]         mode_switch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         module_index,
  output logic signed [24:0] steer_angle,
  output logic [16:0]        wheel_speed,
  output logic               last_module
);
  localparam int N = sdik_pkg::CordicStages;

  logic [13:0] module_radius;
  logic [15:0] speed_gain;
  logic [11:0] yaw_rate_deadband;

  always_ff @(posedge clk) begin
    if (rst) begin
      module_radius <= 14'd3476;
      speed_gain <= 16'd57000;
      yaw_rate_deadband <= 12'd41;
    end else if (cfg_we) begin
      case (cfg_index)
        sdik_pkg::RegRadius:   module_radius <= cfg_data[13:0];
        sdik_pkg::RegGain:     speed_gain <= cfg_data;
        sdik_pkg::RegDeadband: yaw_rate_deadband <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  logic en;
  logic busy;
  logic [1:0] cnt;
  logic signed [15:0] h_vx, h_vy;
  logic signed [16:0] h_w;
  logic signed [24:0] h_a;

  // final stage registers
  logic e1_valid, e2_valid, e3_valid, e4_valid;
  sdik_pkg::tok_t e1;
  logic signed [24:0] e3_a;
  logic [1:0] e2_idx, e3_idx, e4_idx;
  logic e2_last, e3_last, e4_last;
  sdik_pkg::wide_t e2_x;
  logic signed [24:0] e2_a;
  logic signed [24:0] e4_steer;
  logic [16:0] e4_spd;

  logic last_issue;
  assign last_issue = (cnt == 2'(sdik_pkg::NumModules - 1));

  assign en = !out_valid || out_ready;
  assign in_ready = en && (!busy || last_issue);

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  logic signed [16:0] w_in, w_abs;
  always_comb begin
    w_in = 17'(yaw_rate);
    w_abs = w_in < 0 ? -w_in : w_in;
    if (w_abs <= $signed({5'd0, yaw_rate_deadband})) w_in = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (en) begin
      if (in_fire) begin
        busy <= (mode_switch == 2'd1 || mode_switch == 2'd2);
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (last_issue) busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      h_vx <= vel_x;
      h_vy <= vel_y;
      h_w <= w_in;
      h_a <= 25'(heading) - 25'(heading_origin);
    end
  end

  // angle reduction for the issued module
  sdik_pkg::tok_t t0;
  logic signed [26:0] th;
  logic signed [26:0] mount;
  always_comb begin
    mount = 27'(-2880 + int'(cnt) * (sdik_pkg::Deg360 / sdik_pkg::NumModules));
    if (mount > 27'sd11520) mount = mount - 27'sd23040;
    th = 27'(h_a) + mount;
  end

  // modulo reduction split into a registered stage
  logic signed [26:0] r_th;
  logic r_valid;
  logic [1:0] r_idx;
  logic signed [24:0] r_a;
  logic signed [16:0] r_w;
  logic signed [15:0] r_vx, r_vy;
  logic signed [42:0] qprod;
  logic signed [15:0] q;
  always_comb begin
    qprod = 43'(th) * 43'sd11651;   // 2^28/23040
    q = 16'(qprod >>> 28);
  end
  logic signed [26:0] rem0;
  always_comb rem0 = th - 27'(32'(q) * 32'sd23040);

  always_ff @(posedge clk) begin
    if (rst) r_valid <= 1'b0;
    else if (en) r_valid <= busy;
    if (en) begin
      r_th <= rem0;
      r_idx <= cnt;
      r_a <= h_a;
      r_w <= h_w;
      r_vx <= h_vx;
      r_vy <= h_vy;
    end
  end

  logic signed [26:0] rr;
  always_comb begin
    rr = r_th;
    if (rr < 0) rr = rr + 27'sd23040;
    if (rr >= 27'sd23040) rr = rr - 27'sd23040;
    if (rr >= 27'sd11520) rr = rr - 27'sd23040;
    t0.valid = r_valid;
    t0.idx = r_idx;
    t0.last = (r_idx == 2'(sdik_pkg::NumModules - 1));
    t0.a = r_a;
    t0.w = r_w;
    t0.vx = r_vx;
    t0.vy = r_vy;
    t0.neg = 1'b0;
    if (rr > 27'sd5760) begin
      rr = rr - 27'sd11520;
      t0.neg = 1'b1;
    end else if (rr < -27'sd5760) begin
      rr = rr + 27'sd11520;
      t0.neg = 1'b1;
    end
    t0.x = 48'(32'(module_radius) * 32'sd39797);
    t0.y = '0;
    t0.z = 32'(rr) * 32'sd256;
  end

  sdik_pkg::tok_t rc [0:N];
  assign rc[0] = t0;
  for (genvar g = 0; g < N; g++) begin : g_rot
    sdik_rot_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .stage(5'(g)), .din(rc[g]), .dout(rc[g+1])
    );
  end

  // wheel vector: multiply then register
  sdik_pkg::tok_t m1;
  sdik_pkg::wide_t prx, pry;
  always_comb begin
    prx = rc[N].neg ? -rc[N].x : rc[N].x;
    pry = rc[N].neg ? -rc[N].y : rc[N].y;
  end
  logic signed [63:0] pws, pwc;
  always_ff @(posedge clk) begin
    if (rst) m1.valid <= 1'b0;
    else if (en) m1.valid <= rc[N].valid;
    if (en) begin
      m1.idx <= rc[N].idx; m1.last <= rc[N].last; m1.a <= rc[N].a;
      m1.w <= rc[N].w; m1.vx <= rc[N].vx; m1.vy <= rc[N].vy; m1.neg <= 1'b0;
      m1.x <= '0; m1.y <= '0; m1.z <= '0;
      pws <= 64'(rc[N].w) * 64'(pry);
      pwc <= 64'(rc[N].w) * 64'(prx);
    end
  end

  sdik_pkg::tok_t v0;
  sdik_pkg::wide_t wx, wy;
  always_comb begin
    wx = 48'(m1.vx) * 48'sd65536 + 48'(pws >>> 12);
    wy = 48'(m1.vy) * 48'sd65536 - 48'(pwc >>> 12);
    v0 = m1;
    v0.z = '0;
    if (wx < 0) begin
      v0.z = (wy >= 0) ? 32'(sdik_pkg::Z180) : -32'(sdik_pkg::Z180);
      v0.x = -wx;
      v0.y = -wy;
    end else begin
      v0.x = wx;
      v0.y = wy;
    end
    v0.neg = (wx == 0) && (wy == 0);
  end

  sdik_pkg::tok_t vc [0:N];
  always_ff @(posedge clk) begin
    if (rst) vc[0].valid <= 1'b0;
    else if (en) vc[0].valid <= v0.valid;
    if (en) begin
      vc[0].idx <= v0.idx; vc[0].last <= v0.last; vc[0].a <= v0.a;
      vc[0].w <= v0.w; vc[0].vx <= v0.vx; vc[0].vy <= v0.vy;
      vc[0].neg <= v0.neg; vc[0].x <= v0.x; vc[0].y <= v0.y; vc[0].z <= v0.z;
    end
  end
  for (genvar g = 0; g < N; g++) begin : g_vec
    sdik_vec_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .stage(5'(g)), .din(vc[g]), .dout(vc[g+1])
    );
  end

  // magnitude gain and steer
  logic signed [63:0] mprod;
  always_comb mprod = 64'(vc[N].x) * 64'sd39797;
  logic signed [33:0] ang_r;
  always_comb ang_r = 34'(vc[N].neg ? 32'sd0 : vc[N].z) + 34'sd128;

  logic signed [47:0] mag;
  always_ff @(posedge clk) begin
    if (rst) e1_valid <= 1'b0;
    else if (en) e1_valid <= vc[N].valid;
    if (en) begin
      e1 <= vc[N];
      mag <= vc[N].neg ? 48'sd0 : 48'(mprod >>> 16);
      e3_a <= 25'(ang_r >>> 8);
    end
  end

  logic [47:0] magu;
  always_comb magu = mag < 0 ? 48'd0 : 48'(mag);
  logic [47:0] mlo_p, mhi_p;
  always_ff @(posedge clk) begin
    if (rst) e2_valid <= 1'b0;
    else if (en) e2_valid <= e1_valid;
    if (en) begin
      e2_idx <= e1.idx; e2_last <= e1.last; e2_a <= e1.a;
      mlo_p <= 48'(magu[23:0]) * 48'(speed_gain);
      mhi_p <= 48'(magu[47:24]) * 48'(speed_gain);
      e2_x <= 48'(e3_a);
    end
  end

  logic [72:0] sp;
  logic signed [26:0] st;
  always_comb begin
    sp = (73'(mhi_p) << 24) + 73'(mlo_p) + (73'd1 << 31);
    st = 27'(e2_x) - 27'(e2_a);
  end

  always_ff @(posedge clk) begin
    if (rst) e4_valid <= 1'b0;
    else if (en) e4_valid <= e2_valid;
    if (en) begin
      e4_idx <= e2_idx; e4_last <= e2_last;
      e4_spd <= (sp[72:32] > 41'd131071) ? 17'd131071 : sp[48:32];
      e4_steer <= (st > 27'sd16777215) ? 25'sd16777215 :
                  (st < -27'sd16777216) ? 25'(-27'sd16777216) : 25'(st);
    end
  end
  assign e3_valid = e4_valid;
  assign e3_idx = e4_idx;
  assign e3_last = e4_last;

  assign out_valid = e3_valid;
  assign module_index = e3_idx;
  assign last_module = e3_last;
  assign wheel_speed = e4_spd;
  assign steer_angle = e4_steer;

  assert property (@(posedge clk) disable iff (rst) in_fire |=> !in_ready || !busy)
    else $error("item accepted while modules pending");
  assert property (@(posedge clk) disable iff (rst) out_valid && !out_ready |=> out_valid)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (rst)
    out_valid && last_module |-> module_index == 2'(sdik_pkg::NumModules - 1))
    else $error("last flag on wrong module");
endmodule

// ----- sv/sdik_rot_cell.sv -----
module sdik_rot_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [4:0]     stage,
  input  sdik_pkg::tok_t din,
  output sdik_pkg::tok_t dout
);
  sdik_pkg::tok_t nxt;
  sdik_pkg::wide_t dx, dy;

  always_comb begin
    dx = din.x >>> stage;
    dy = din.y >>> stage;
    nxt = din;
    if (din.z >= 0) begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - sdik_pkg::atan_entry(stage);
    end else begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + sdik_pkg::atan_entry(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
    if (en) begin
      dout.idx <= nxt.idx;
      dout.last <= nxt.last;
      dout.a <= nxt.a;
      dout.w <= nxt.w;
      dout.vx <= nxt.vx;
      dout.vy <= nxt.vy;
      dout.neg <= nxt.neg;
      dout.x <= nxt.x;
      dout.y <= nxt.y;
      dout.z <= nxt.z;
    end
  end
endmodule

// ----- sv/sdik_vec_cell.sv -----
module sdik_vec_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [4:0]     stage,
  input  sdik_pkg::tok_t din,
  output sdik_pkg::tok_t dout
);
  sdik_pkg::tok_t nxt;
  sdik_pkg::wide_t dx, dy;

  always_comb begin
    dx = din.x >>> stage;
    dy = din.y >>> stage;
    nxt = din;
    if (din.y >= 0) begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + sdik_pkg::atan_entry(stage);
    end else begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - sdik_pkg::atan_entry(stage);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= nxt.valid;
    end
    if (en) begin
      dout.idx <= nxt.idx;
      dout.last <= nxt.last;
      dout.a <= nxt.a;
      dout.w <= nxt.w;
      dout.vx <= nxt.vx;
      dout.vy <= nxt.vy;
      dout.neg <= nxt.neg;
      dout.x <= nxt.x;
      dout.y <= nxt.y;
      dout.z <= nxt.z;
    end
  end
endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [24:0] steer;
    logic [16:0]        speed;
    logic               last;
  } wheel_cmd_t;

  localparam longint AtanTab [0:23] = '{
    737280, 435242, 229970, 116736, 58595, 29326, 14667, 7334,
    3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0};
  localparam int Latency = 80;

  logic clk, rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic signed [15:0] vel_x, vel_y, yaw_rate;
  logic signed [23:0] heading, heading_origin;
  logic [1:0] mode_switch;
  logic out_valid, out_ready;
  logic [1:0] module_index;
  logic signed [24:0] steer_angle;
  logic [16:0] wheel_speed;
  logic last_module;

  longint radius_q, gain_q, deadband_q;
  wheel_cmd_t cmd_q[$];
  int errors = 0;
  longint cycles = 0;
  int hold_off = 0;
  int stall_len = 0;
  bit stall_req = 1'b0;
  bit stall_ack = 1'b0;
  bit burst_mode;

  swerve_drive_inverse_kinematics_top u_top (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 50000) begin
      $display("** swerve_drive_inverse_kinematics_top: FAILED **");
      $finish;
    end
  end

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  task automatic rotate_radius(longint th, output longint rc, output longint rs);
    bit neg;
    longint x, y, z, nx;
    neg = 0;
    if (th > sdik_pkg::Deg90) begin
      th -= sdik_pkg::Deg180;
      neg = 1;
    end else if (th < -sdik_pkg::Deg90) begin
      th += sdik_pkg::Deg180;
      neg = 1;
    end
    x = radius_q * sdik_pkg::GainQ16;
    y = 0;
    z = th * 256;
    for (int i = 0; i < sdik_pkg::CordicStages; i++) begin
      if (z >= 0) begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= AtanTab[i];
      end else begin
        nx = x + asr(y, i); y = y - asr(x, i); z += AtanTab[i];
      end
      x = nx;
    end
    rc = neg ? -x : x;
    rs = neg ? -y : y;
  endtask

  task automatic polar(longint x, longint y, output longint ang, output longint mag);
    longint z, nx;
    z = 0;
    if (x == 0 && y == 0) begin
      ang = 0; mag = 0;
      return;
    end
    if (x < 0) begin
      z = (y >= 0) ? sdik_pkg::Z180 : -sdik_pkg::Z180;
      x = -x; y = -y;
    end
    for (int i = 0; i < sdik_pkg::CordicStages; i++) begin
      if (y >= 0) begin
        nx = x + asr(y, i); y = y - asr(x, i); z += AtanTab[i];
      end else begin
        nx = x - asr(y, i); y = y + asr(x, i); z -= AtanTab[i];
      end
      x = nx;
    end
    ang = z;
    mag = asr(x * sdik_pkg::GainQ16, 16);
    if (mag < 0) mag = 0;
  endtask

  task automatic predict_wheels(longint vx, longint vy, longint w, longint hd,
                                longint org, logic [1:0] mode);
    longint a, mount, th, rc, rs, wx, wy, ang, mag, steer;
    longint unsigned spd;
    wheel_cmd_t c;
    a = hd - org;
    if (mode != 2'd1 && mode != 2'd2) return;
    if ((w < 0 ? -w : w) <= deadband_q) w = 0;
    for (int i = 0; i < sdik_pkg::NumModules; i++) begin
      mount = -2880 + (longint'(i) * sdik_pkg::Deg360) / sdik_pkg::NumModules;
      if (mount > sdik_pkg::Deg180) mount -= sdik_pkg::Deg360;
      th = (a + mount) % sdik_pkg::Deg360;
      if (th < 0) th += sdik_pkg::Deg360;
      if (th >= sdik_pkg::Deg180) th -= sdik_pkg::Deg360;
      rotate_radius(th, rc, rs);
      wx = vx * 65536 + asr(w * rs, 12);
      wy = vy * 65536 - asr(w * rc, 12);
      polar(wx, wy, ang, mag);
      steer = asr(ang + 128, 8) - a;
      if (steer > 16777215) steer = 16777215;
      if (steer < -16777216) steer = -16777216;
      spd = (longint'(mag) * gain_q + (64'd1 << 31)) >> 32;
      if (spd > 131071) spd = 131071;
      c.idx = 2'(i);
      c.steer = 25'(steer);
      c.speed = 17'(spd);
      c.last = (i == sdik_pkg::NumModules - 1);
      cmd_q.push_back(c);
    end
  endtask

  task automatic report(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d", what, got, exp_v);
    errors++;
  endtask

  always @(posedge clk) begin
    wheel_cmd_t e;
    if (!rst && out_valid && out_ready) begin
      if (cmd_q.size() == 0) report("unexpected item", module_index, -1);
      else begin
        e = cmd_q.pop_front();
        if (module_index !== e.idx) report("module_index", module_index, e.idx);
        if (steer_angle !== e.steer) report("steer_angle", steer_angle, e.steer);
        if (wheel_speed !== e.speed) report("wheel_speed", wheel_speed, e.speed);
        if (last_module !== e.last) report("last_module", last_module, e.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b1;
    else if (stall_req != stall_ack) begin
      stall_ack <= stall_req;
      hold_off <= stall_len;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      out_ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (burst_mode) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_cmd(logic [15:0] vx, logic [15:0] vy, logic [15:0] w,
                          logic [23:0] hd, logic [23:0] org, logic [1:0] mode,
                          bit gaps = 1);
    if (gaps && !burst_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    vel_x <= vx; vel_y <= vy; yaw_rate <= w;
    heading <= hd; heading_origin <= org; mode_switch <= mode;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_wheels(longint'($signed(vx)), longint'($signed(vy)), longint'($signed(w)),
                   longint'($signed(hd)), longint'($signed(org)), mode);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (cmd_q.size() != 0) @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sdik_pkg::RegRadius:   radius_q = val & 16'h3FFF;
      sdik_pkg::RegGain:     gain_q = val;
      sdik_pkg::RegDeadband: deadband_q = val & 16'hFFF;
      default: ;
    endcase
  endtask

  task automatic send_random(int n);
    logic [1:0] mode;
    for (int k = 0; k < n; k++) begin
      mode = ($urandom_range(0, 9) == 0) ? 2'(($urandom_range(0, 1)) * 3)
                                         : 2'($urandom_range(1, 2));
      if ($urandom_range(0, 1))
        send_cmd(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
                 24'($urandom), mode);
      else
        send_cmd(16'($urandom_range(0, 8191) - 4096), 16'($urandom_range(0, 8191) - 4096),
                 16'($urandom_range(0, 16383) - 8192),
                 24'($urandom_range(0, 46080) - 23040),
                 24'($urandom_range(0, 2000) - 1000), mode);
      if ($urandom_range(0, 15) == 0) burst_mode = ~burst_mode;
    end
  endtask

  task automatic test_directed();
    send_cmd(16'h0000, 16'h0000, 16'h0000, 24'd0, 24'd0, 2'd1);
    send_cmd(16'h7FFF, 16'h7FFF, 16'h7FFF, 24'h7FFFFF, 24'h800000, 2'd2);
    send_cmd(16'h8000, 16'h8000, 16'h8000, 24'h800000, 24'h7FFFFF, 2'd1);
    send_cmd(16'h8000, 16'h0000, 16'h0000, 24'd0, 24'd0, 2'd1);
    send_cmd(16'h8000, 16'hFFFF, 16'h0000, 24'd0, 24'd0, 2'd2);
    send_cmd(16'h1000, 16'h0000, 16'd41, 24'd0, 24'd0, 2'd1);
    send_cmd(16'h1000, 16'h0000, 16'd42, 24'd0, 24'd0, 2'd1);
    send_cmd(16'h1000, 16'h0000, -16'sd41, 24'd0, 24'd0, 2'd1);
    send_cmd(16'h1000, 16'h0000, -16'sd42, 24'd5760, 24'd0, 2'd2);
    send_cmd(16'h0000, 16'h0000, 16'h4000, 24'd11520, -24'sd11520, 2'd1);
    send_cmd(16'h0000, 16'h1000, 16'hC000, -24'sd5761, 24'd5761, 2'd2);
    send_cmd(16'h1234, 16'h4321, 16'h2000, 24'd1000, 24'd0, 2'd0);
    send_cmd(16'h1234, 16'h4321, 16'h2000, 24'd1000, 24'd0, 2'd3);
    send_cmd(16'h0000, 16'h0000, 16'h7FFF, 24'h700000, 24'h900000, 2'd1);
    send_cmd(16'hFFFF, 16'h5555, 16'hAAAA, 24'h555555, 24'hAAAAAA, 2'd2);
  endtask

  task automatic test_config_sweep();
    write_reg(sdik_pkg::RegRadius, 16'h3FFF);
    write_reg(sdik_pkg::RegGain, 16'hFFFF);
    write_reg(sdik_pkg::RegDeadband, 16'h0FFF);
    send_random(10);
    write_reg(sdik_pkg::RegRadius, 16'h0000);
    write_reg(sdik_pkg::RegGain, 16'h0000);
    write_reg(sdik_pkg::RegDeadband, 16'h0000);
    send_random(8);
    write_reg(sdik_pkg::RegRadius, 16'd3476);
    write_reg(sdik_pkg::RegGain, 16'd57000);
    write_reg(sdik_pkg::RegDeadband, 16'd41);
  endtask

  task automatic test_backpressure();
    drain();
    stall_len = 300;
    stall_req = ~stall_req;
    burst_mode = 1;
    for (int k = 0; k < 12; k++)
      send_cmd(16'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
               24'($urandom), 2'd1, 1'b0);
    burst_mode = 0;
    drain();
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    in_valid = 0; vel_x = 0; vel_y = 0; yaw_rate = 0;
    heading = 0; heading_origin = 0; mode_switch = 0;
    burst_mode = 0;
    radius_q = 3476; gain_q = 57000; deadband_q = 41;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    send_random(55);
    drain();
    if (errors == 0) $display("** swerve_drive_inverse_kinematics_top: PASSED **");
    else $display("** swerve_drive_inverse_kinematics_top: FAILED **");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sdik_pkg.sv
sv/sdik_rot_cell.sv
sv/sdik_vec_cell.sv
sv/swerve_drive_inverse_kinematics_top.sv
dv/tb_top.sv
